/* rtl/core/trr_pkg.sv */
// Package for the ranged Tausworthe random number block.
// Holds the sequencer state type, seed and mask constants and the component step.
// No dependencies.
package trr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } trr_state_t;

  localparam int unsigned RawW  = 31;
  localparam int unsigned BndW  = 16;
  localparam int unsigned SpanW = 17;

  localparam logic [31:0] SEED   = 32'd12345;
  localparam logic [31:0] KEEP_1 = 32'hFFFF_FFFE;
  localparam logic [31:0] KEEP_2 = 32'hFFFF_FFF8;
  localparam logic [31:0] KEEP_3 = 32'hFFFF_FFF0;
  localparam logic [31:0] KEEP_4 = 32'hFFFF_FF80;

  localparam logic [4:0] LAST_BIT = 5'(RawW - 1);

  // One Tausworthe step: feedback from shifts q and s, keep mask, shift k.
  function automatic logic [31:0] taus_step(
    input logic [31:0] z,
    input logic [4:0]  q,
    input logic [4:0]  s,
    input logic [31:0] keep,
    input logic [4:0]  k
  );
    logic [31:0] fb;
    fb = ((z << q) ^ z) >> s;
    return ((z & keep) << k) ^ fb;
  endfunction

endpackage

/* rtl/core/trr_req_if.sv */
// Request channel of the ranged random number block: two signed bounds.
// Uses no package.
interface trr_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] bound_a;
  logic signed [15:0] bound_b;

  modport source (output valid, output bound_a, output bound_b, input ready);
  modport sink   (input valid, input bound_a, input bound_b, output ready);
endinterface

/* rtl/core/trr_rsp_if.sv */
// Result channel of the ranged random number block: ranged and raw values.
// Uses no package.
interface trr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ranged_value;
  logic        [30:0] raw_value;

  modport source (output valid, output ranged_value, output raw_value, input ready);
  modport sink   (input valid, input ranged_value, input raw_value, output ready);
endinterface

/* rtl/core/tausworthe_random_range.sv */
// Top level of the ranged random number block: lfsr113 generator and serial remainder.
// Depends on trr_pkg, trr_req_if and trr_rsp_if.

// Each request beat carries two signed 16-bit bounds in either order. On accept the
// four lfsr113 components (seeded with 12345 at reset) advance once and their XOR,
// shifted right by one, is the 31-bit raw value. The ranged value is raw modulo
// (max - min + 1) plus min, computed by a restoring remainder unit that takes one
// dividend bit per cycle. An item passes from the accept through 31 remainder steps
// to a load state that writes the output register and waits there while an earlier
// result is still untaken. in_ch.ready is high only while the sequencer is
// idle. The result sits in an output register, so a new request can be accepted
// while the previous result still waits to be taken.
module tausworthe_random_range (
  input  logic         clk,
  input  logic         rst_n,
  trr_req_if.sink      in_ch,
  trr_rsp_if.source    out_ch
);

  trr_pkg::trr_state_t state_r, state_nxt;

  logic [31:0] comp1_r, comp1_nxt;
  logic [31:0] comp2_r, comp2_nxt;
  logic [31:0] comp3_r, comp3_nxt;
  logic [31:0] comp4_r, comp4_nxt;

  logic [trr_pkg::RawW-1:0]  raw_r, raw_nxt;
  logic [trr_pkg::RawW-1:0]  div_r, div_nxt;
  logic [trr_pkg::SpanW-1:0] span_r, span_nxt;
  logic [trr_pkg::BndW-1:0]  lo_r, lo_nxt;
  logic [trr_pkg::BndW-1:0]  rem_r, rem_nxt;
  logic [4:0]                cnt_r, cnt_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [trr_pkg::BndW-1:0]  out_ranged_r, out_ranged_nxt;
  logic [trr_pkg::RawW-1:0]  out_raw_r, out_raw_nxt;

  logic                      in_ready;
  logic                      start;
  logic                      load_out;

  logic signed [15:0]        lo_in, hi_in;
  logic [trr_pkg::SpanW-1:0] span_in;
  logic [31:0]               n1, n2, n3, n4;
  logic [trr_pkg::SpanW-1:0] trial;
  logic                      fits;

  // Sequencer outputs
  always_comb begin
    in_ready = (state_r == trr_pkg::ST_IDLE);
    start    = in_ready && in_ch.valid;
    load_out = (state_r == trr_pkg::ST_LOAD) && (!out_valid_r || out_ch.ready);
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trr_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = trr_pkg::ST_DIV;
      end
      trr_pkg::ST_DIV: begin
        if (cnt_r == 5'd0) state_nxt = trr_pkg::ST_LOAD;
      end
      trr_pkg::ST_LOAD: begin
        if (!out_valid_r || out_ch.ready) state_nxt = trr_pkg::ST_IDLE;
      end
      default: state_nxt = trr_pkg::ST_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    if (in_ch.bound_b < in_ch.bound_a) begin
      lo_in = in_ch.bound_b;
      hi_in = in_ch.bound_a;
    end else begin
      lo_in = in_ch.bound_a;
      hi_in = in_ch.bound_b;
    end
    span_in = {hi_in[15], hi_in} - {lo_in[15], lo_in} + 17'd1;

    n1 = trr_pkg::taus_step(comp1_r, 5'd6,  5'd13, trr_pkg::KEEP_1, 5'd18);
    n2 = trr_pkg::taus_step(comp2_r, 5'd2,  5'd27, trr_pkg::KEEP_2, 5'd2);
    n3 = trr_pkg::taus_step(comp3_r, 5'd13, 5'd21, trr_pkg::KEEP_3, 5'd7);
    n4 = trr_pkg::taus_step(comp4_r, 5'd3,  5'd12, trr_pkg::KEEP_4, 5'd13);

    // Restoring remainder step on the next dividend bit
    trial = {rem_r, div_r[trr_pkg::RawW-1]};
    fits  = (trial >= span_r);

    comp1_nxt = comp1_r;
    comp2_nxt = comp2_r;
    comp3_nxt = comp3_r;
    comp4_nxt = comp4_r;
    raw_nxt   = raw_r;
    div_nxt   = div_r;
    span_nxt  = span_r;
    lo_nxt    = lo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;

    if (start) begin
      comp1_nxt = n1;
      comp2_nxt = n2;
      comp3_nxt = n3;
      comp4_nxt = n4;
      raw_nxt   = 31'((n1 ^ n2 ^ n3 ^ n4) >> 1);
      div_nxt   = 31'((n1 ^ n2 ^ n3 ^ n4) >> 1);
      span_nxt  = span_in;
      lo_nxt    = lo_in;
      rem_nxt   = '0;
      cnt_nxt   = trr_pkg::LAST_BIT;
    end else if (state_r == trr_pkg::ST_DIV) begin
      rem_nxt = fits ? 16'(trial - span_r) : trial[15:0];
      div_nxt = {div_r[trr_pkg::RawW-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
    end

    out_ranged_nxt = out_ranged_r;
    out_raw_nxt    = out_raw_r;
    out_valid_nxt  = out_valid_r;
    if (load_out) begin
      out_ranged_nxt = lo_r + rem_r;
      out_raw_nxt    = raw_r;
      out_valid_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      comp1_r     <= trr_pkg::SEED;
      comp2_r     <= trr_pkg::SEED;
      comp3_r     <= trr_pkg::SEED;
      comp4_r     <= trr_pkg::SEED;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      comp1_r     <= comp1_nxt;
      comp2_r     <= comp2_nxt;
      comp3_r     <= comp3_nxt;
      comp4_r     <= comp4_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r        <= raw_nxt;
    div_r        <= div_nxt;
    span_r       <= span_nxt;
    lo_r         <= lo_nxt;
    rem_r        <= rem_nxt;
    out_ranged_r <= out_ranged_nxt;
    out_raw_r    <= out_raw_nxt;
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.ranged_value = out_ranged_r;
  assign out_ch.raw_value    = out_raw_r;

`ifndef SYNTHESIS
  // An accepted beat starts the remainder loop at the top dividend bit
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == trr_pkg::ST_DIV) && (cnt_r == trr_pkg::LAST_BIT))
    else $error("remainder loop did not start after accept");

  // Partial remainder stays below the span
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trr_pkg::ST_DIV || state_r == trr_pkg::ST_LOAD) |->
      ({1'b0, rem_r} < span_r))
    else $error("partial remainder not below span");

  // Loading the output register always presents a result next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == trr_pkg::ST_IDLE))
    else $error("result not presented after load");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for tausworthe_random_range: directed bound table, then random beats.
// Depends on trr_req_if, trr_rsp_if and the tausworthe_random_range top level.
module tb;

  localparam int unsigned RANDOM_BEATS = 1434;
  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned CALM_STRETCH = 128;
  localparam int unsigned HOLD_OFF     = 600;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [31:0] SEED_WORD = 32'd12345;
  localparam logic [31:0] MASK_ONE   = 32'hFFFF_FFFE;
  localparam logic [31:0] MASK_TWO   = 32'hFFFF_FFF8;
  localparam logic [31:0] MASK_THREE = 32'hFFFF_FFF0;
  localparam logic [31:0] MASK_FOUR  = 32'hFFFF_FF80;

  localparam int BOUND_MIN = -32768;
  localparam int BOUND_MAX = 32767;

  typedef struct packed {
    logic signed [15:0] ranged;
    logic        [30:0] raw;
  } draw_t;

  typedef struct packed {
    logic signed [15:0] bound_a;
    logic signed [15:0] bound_b;
    logic               pinned;
    logic signed [15:0] pinned_ranged;
  } bound_row_t;

  localparam int unsigned ROW_COUNT = 16;

  // Equal bounds pin the ranged value; everything else goes through the predictor.
  bound_row_t bound_rows [ROW_COUNT] = '{
    '{16'sd0,       16'sd0,       1'b1, 16'sd0},
    '{-16'sd32768,  -16'sd32768,  1'b1, -16'sd32768},
    '{16'sd32767,   16'sd32767,   1'b1, 16'sd32767},
    '{-16'sd32768,  16'sd32767,   1'b0, 16'sd0},
    '{16'sd32767,   -16'sd32768,  1'b0, 16'sd0},
    '{16'sd10,      -16'sd10,     1'b0, 16'sd0},
    '{-16'sd10,     16'sd10,      1'b0, 16'sd0},
    '{16'sd0,       16'sd1,       1'b0, 16'sd0},
    '{16'sd1,       16'sd0,       1'b0, 16'sd0},
    '{-16'sd1,      -16'sd1,      1'b1, -16'sd1},
    '{16'sd21845,   -16'sd21846,  1'b0, 16'sd0},
    '{-16'sd21846,  16'sd21845,   1'b0, 16'sd0},
    '{16'sd0,       -16'sd1,      1'b0, 16'sd0},
    '{16'sd32767,   16'sd32766,   1'b0, 16'sd0},
    '{-16'sd32768,  -16'sd32767,  1'b0, 16'sd0},
    '{16'sd12345,   16'sd12345,   1'b1, 16'sd12345}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  trr_req_if req_ch ();
  trr_rsp_if rsp_ch ();

  tausworthe_random_range dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always #10 clk = ~clk;

  logic [31:0] lfsr_words [4];
  draw_t       pending_draws [$];
  int unsigned mismatch_count = 0;
  int unsigned results_taken = 0;
  int unsigned cycle_count = 0;
  bit          sender_done = 1'b0;

  function automatic logic [31:0] lfsr_advance(input logic [31:0] word, input int unsigned q,
                                               input int unsigned s, input logic [31:0] keep,
                                               input int unsigned k);
    logic [31:0] feedback;
    logic [31:0] kept;
    feedback = (word ^ (word << q)) >> s;
    kept     = (word & keep) << k;
    return kept ^ feedback;
  endfunction

  // Advance the generator once and form the ranged and raw values for one request.
  function automatic draw_t draw_next_value(input logic signed [15:0] bound_a,
                                            input logic signed [15:0] bound_b);
    int          lo;
    int          hi;
    int          swap;
    int unsigned span;
    int unsigned raw_word;
    int          remainder;
    logic [31:0] mix;
    draw_t       result;
    lo = bound_a;
    hi = bound_b;
    if (hi < lo) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    lfsr_words[0] = lfsr_advance(lfsr_words[0], 6,  13, MASK_ONE,   18);
    lfsr_words[1] = lfsr_advance(lfsr_words[1], 2,  27, MASK_TWO,   2);
    lfsr_words[2] = lfsr_advance(lfsr_words[2], 13, 21, MASK_THREE, 7);
    lfsr_words[3] = lfsr_advance(lfsr_words[3], 3,  12, MASK_FOUR,  13);
    mix        = lfsr_words[0] ^ lfsr_words[1] ^ lfsr_words[2] ^ lfsr_words[3];
    result.raw = mix[31:1];
    raw_word   = {1'b0, result.raw};
    span       = int'(hi - lo + 1);
    remainder  = int'(raw_word % span);
    result.ranged = 16'(remainder + lo);
    return result;
  endfunction

  function automatic int clamp_bound(input int value);
    if (value > BOUND_MAX) return BOUND_MAX;
    if (value < BOUND_MIN) return BOUND_MIN;
    return value;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0:       return BOUND_MIN;
      1:       return BOUND_MAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Mix of range shapes: wide, narrow, degenerate, extreme and power-of-two spans.
  task automatic pick_bounds(output logic signed [15:0] bound_a,
                             output logic signed [15:0] bound_b);
    int a;
    int b;
    int shift;
    a = int'($signed(16'($urandom())));
    b = int'($signed(16'($urandom())));
    case ($urandom_range(0, 9))
      4, 5: b = clamp_bound(a + int'($urandom_range(0, 16)) - 8);
      6:    b = a;
      7: begin
        a = pick_extreme();
        b = pick_extreme();
      end
      8: begin
        shift = $urandom_range(0, 16);
        b = clamp_bound(a + (1 << shift) - 1);
        if ($urandom_range(0, 1) == 1) begin
          shift = a;
          a = b;
          b = shift;
        end
      end
      9: begin
        a = BOUND_MAX;
        b = BOUND_MIN;
      end
      default: ;
    endcase
    bound_a = 16'(a);
    bound_b = 16'(b);
  endtask

  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Offer one beat and wait for it to be taken; record its expectation at the accept edge.
  task automatic offer_bounds(input logic signed [15:0] bound_a,
                              input logic signed [15:0] bound_b, input bit calm,
                              input bit pinned, input logic signed [15:0] pinned_ranged);
    int unsigned gap;
    draw_t       expect_draw;
    gap = draw_gap(calm);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.bound_a <= bound_a;
    req_ch.bound_b <= bound_b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expect_draw = draw_next_value(bound_a, bound_b);
    if (pinned) expect_draw.ranged = pinned_ranged;
    pending_draws.push_back(expect_draw);
  endtask

  task automatic report_mismatch(input string field, input longint expect_val,
                                 input longint actual_val);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, expect_val,
             actual_val);
    mismatch_count++;
  endtask

  // Request side
  initial begin
    logic signed [15:0] bound_a;
    logic signed [15:0] bound_b;
    bit                 calm;
    req_ch.valid   = 1'b0;
    req_ch.bound_a = '0;
    req_ch.bound_b = '0;
    lfsr_words     = '{SEED_WORD, SEED_WORD, SEED_WORD, SEED_WORD};
    calm           = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (int unsigned row = 0; row < ROW_COUNT; row++) begin
      offer_bounds(bound_rows[row].bound_a, bound_rows[row].bound_b, 1'b0,
                   bound_rows[row].pinned, bound_rows[row].pinned_ranged);
    end
    for (int unsigned beat = 0; beat < RANDOM_BEATS; beat++) begin
      if (beat % CALM_STRETCH == 0) calm = ($urandom_range(0, 3) == 0);
      pick_bounds(bound_a, bound_b);
      offer_bounds(bound_a, bound_b, calm, 1'b0, 16'sd0);
    end
    req_ch.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Result side, with one long hold-off so the block backs up into its input
  initial begin
    draw_t       expect_draw;
    int unsigned gap;
    bit          calm;
    bit          held;
    rsp_ch.ready = 1'b0;
    calm         = 1'b0;
    held         = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken % CALM_STRETCH == 0) calm = ($urandom_range(0, 3) == 0);
      gap = draw_gap(calm);
      if (!held && results_taken == HOLD_AT) begin
        held = 1'b1;
        gap  = HOLD_OFF;
      end
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      results_taken++;
      if (pending_draws.size() == 0) begin
        $display("%0t ns: result beat, expected none, actual ranged %0d raw %0d",
                 $time, rsp_ch.ranged_value, rsp_ch.raw_value);
        mismatch_count++;
      end else begin
        expect_draw = pending_draws.pop_front();
        if (rsp_ch.ranged_value !== expect_draw.ranged)
          report_mismatch("ranged_value", expect_draw.ranged, rsp_ch.ranged_value);
        if (rsp_ch.raw_value !== expect_draw.raw)
          report_mismatch("raw_value", expect_draw.raw, rsp_ch.raw_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (!sender_done) @(posedge clk);
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* tausworthe_random_range.f */
rtl/core/trr_pkg.sv
rtl/core/trr_req_if.sv
rtl/core/trr_rsp_if.sv
rtl/core/tausworthe_random_range.sv
bench/tb.sv
